// File: rtl/hpt_pkg.sv
// Shared types and constants for the hashed position table.
package hpt_pkg;

  localparam int HASH_W   = 32;
  localparam int POS_W    = 32;
  localparam int KEY_W    = 64;
  localparam int Q_DEPTH  = 2;

  typedef enum logic [2:0] {
    KIND_GET   = 3'd0,
    KIND_SET   = 3'd1,
    KIND_UNSET = 3'd2,
    KIND_RESET = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SEARCH  = 2'd2,
    ST_NOENT   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TAG_SEARCH = 2'd0,
    TAG_EMPTY  = 2'd1,
    TAG_VALID  = 2'd2
  } tag_t;

  typedef enum logic [2:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_MOD,
    BK_READ,
    BK_EXEC,
    BK_CLR_DONE
  } bk_state_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [KEY_W-1:0] key_w0;
    logic [KEY_W-1:0] key_w1;
    logic [KEY_W-1:0] key_w2;
    logic [KEY_W-1:0] key_w3;
    logic [POS_W-1:0] new_position;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] found_position;
  } rsp_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [HASH_W-1:0] hash;
    logic [POS_W-1:0]  pos;
  } q_item_t;

  typedef struct packed {
    tag_t             tag;
    logic [POS_W-1:0] pos;
  } entry_t;

endpackage

// File: rtl/hpt_chan_if.sv
// Valid/ready channel carrying one payload item per transfer.
interface hpt_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/hpt_front.sv
// Front end: takes requests and reduces the key to a 32-bit word sum.
module hpt_front (
  input  logic               clk,
  input  logic               rst,
  hpt_chan_if.sink           req,
  input  logic               hold,
  input  logic               q_full,
  output logic               q_push,
  output hpt_pkg::q_item_t   q_item
);

  logic                          s1_valid;
  logic [2:0]                    s1_kind;
  logic [hpt_pkg::POS_W-1:0]     s1_pos;
  logic [hpt_pkg::HASH_W-1:0]    s1_pair [4];
  logic                          accept;

  assign q_push    = s1_valid && !q_full;
  assign req.ready = !hold && (!s1_valid || !q_full);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  // First level of the adder tree: each 64-bit lane holds two key words.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind     <= req.data.kind;
      s1_pos      <= req.data.new_position;
      s1_pair[0]  <= req.data.key_w0[31:0] + req.data.key_w0[63:32];
      s1_pair[1]  <= req.data.key_w1[31:0] + req.data.key_w1[63:32];
      s1_pair[2]  <= req.data.key_w2[31:0] + req.data.key_w2[63:32];
      s1_pair[3]  <= req.data.key_w3[31:0] + req.data.key_w3[63:32];
    end
  end

  always_comb begin
    q_item.kind = s1_kind;
    q_item.pos  = s1_pos;
    q_item.hash = (s1_pair[0] + s1_pair[1]) + (s1_pair[2] + s1_pair[3]);
  end

endmodule

// File: rtl/hpt_queue.sv
// Short queue that decouples the front end from the table engine.
module hpt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hpt_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output hpt_pkg::q_item_t pop_item,
  output logic             empty
);

  localparam int PTR_W = (hpt_pkg::Q_DEPTH > 1) ? $clog2(hpt_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(hpt_pkg::Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(hpt_pkg::Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(hpt_pkg::Q_DEPTH);

  hpt_pkg::q_item_t   slots [hpt_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue count out of range");
`endif

endmodule

// File: rtl/hpt_back.sv
// Table engine: index reduction, entry read-modify-write and clearing sweep.
module hpt_back #(
  parameter int          TABLE_DEPTH    = 4096,
  parameter logic [31:0] POSITION_LIMIT = 32'hFFFF_FFFF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  hpt_pkg::q_item_t q_item,
  output logic             q_pop,
  output logic             init_busy,
  hpt_chan_if.source       rsp
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam bit IS_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] DEPTH_LO = IDX_W'(TABLE_DEPTH);
  localparam int PROD_W = 2 * hpt_pkg::HASH_W + 1;
  localparam int Q_SHIFT = hpt_pkg::HASH_W + IDX_W;
  // Rounded-up reciprocal: the quotient it gives is exact for every 32-bit hash.
  localparam logic [hpt_pkg::HASH_W:0] RECIP = (hpt_pkg::HASH_W + 1)'(
    ((64'd1 << Q_SHIFT) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));

  hpt_pkg::entry_t mem [TABLE_DEPTH];

  hpt_pkg::bk_state_t          state, state_next;
  logic [IDX_W-1:0]            idx, idx_next;
  logic [IDX_W-1:0]            sweep_addr, sweep_addr_next;
  logic                        sweep_resp, sweep_resp_next;
  logic [2:0]                  cur_kind, cur_kind_next;
  logic [hpt_pkg::POS_W-1:0]   cur_pos, cur_pos_next;
  logic [hpt_pkg::HASH_W-1:0]  mod_q, mod_q_next;
  logic [hpt_pkg::HASH_W-1:0]  mod_sh, mod_sh_next;
  hpt_pkg::entry_t             rd_data;
  logic                        rsp_valid;
  hpt_pkg::rsp_t               rsp_data;

  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  hpt_pkg::entry_t             mem_wdata;
  logic                        rsp_load;
  hpt_pkg::status_t            rsp_status;
  logic [hpt_pkg::POS_W-1:0]   rsp_found;
  logic                        dispatch;
  logic                        out_free;
  logic [IDX_W-1:0]            rem_t;
  logic [IDX_W-1:0]            qd_t;
  logic [PROD_W-1:0]           prod_t;
  logic [PROD_W-1:0]           quo_t;

  assign out_free  = !rsp_valid || rsp.ready;
  assign init_busy = (state == hpt_pkg::BK_SWEEP) && !sweep_resp;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hpt_pkg::BK_SWEEP;
      sweep_addr <= '0;
      sweep_resp <= 1'b0;
    end else begin
      state      <= state_next;
      sweep_addr <= sweep_addr_next;
      sweep_resp <= sweep_resp_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    cur_kind <= cur_kind_next;
    cur_pos  <= cur_pos_next;
    mod_q    <= mod_q_next;
    mod_sh   <= mod_sh_next;
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    sweep_addr_next = sweep_addr;
    sweep_resp_next = sweep_resp;
    cur_kind_next   = cur_kind;
    cur_pos_next    = cur_pos;
    mod_q_next      = mod_q;
    mod_sh_next     = mod_sh;
    q_pop           = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_wdata       = '{tag: hpt_pkg::TAG_SEARCH, pos: '0};
    rsp_load        = 1'b0;
    rsp_status      = hpt_pkg::ST_OK;
    rsp_found       = '0;
    dispatch        = 1'b0;
    rem_t           = '0;
    qd_t            = '0;
    prod_t          = '0;
    quo_t           = '0;

    case (state)
      hpt_pkg::BK_SWEEP: begin
        mem_we          = 1'b1;
        mem_waddr       = sweep_addr;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == LAST_ADDR) begin
          sweep_addr_next = '0;
          state_next      = sweep_resp ? hpt_pkg::BK_CLR_DONE : hpt_pkg::BK_IDLE;
        end
      end
      hpt_pkg::BK_CLR_DONE: begin
        if (out_free) begin
          rsp_load        = 1'b1;
          sweep_resp_next = 1'b0;
          dispatch        = 1'b1;
        end
      end
      hpt_pkg::BK_IDLE: begin
        dispatch = 1'b1;
      end
      hpt_pkg::BK_MOD: begin
        // The remainder is below the depth, so only the low index bits are needed.
        qd_t       = mod_q[IDX_W-1:0] * DEPTH_LO;
        rem_t      = mod_sh[IDX_W-1:0] - qd_t;
        idx_next   = rem_t;
        state_next = hpt_pkg::BK_READ;
      end
      hpt_pkg::BK_READ: begin
        state_next = hpt_pkg::BK_EXEC;
      end
      hpt_pkg::BK_EXEC: begin
        if (out_free) begin
          rsp_load = 1'b1;
          dispatch = 1'b1;
          case (cur_kind)
            hpt_pkg::KIND_GET: begin
              if (rd_data.tag == hpt_pkg::TAG_SEARCH) begin
                rsp_status = hpt_pkg::ST_SEARCH;
              end else if (rd_data.tag != hpt_pkg::TAG_VALID) begin
                rsp_status = hpt_pkg::ST_NOENT;
              end else begin
                rsp_found = rd_data.pos;
              end
            end
            hpt_pkg::KIND_SET: begin
              if (cur_pos >= POSITION_LIMIT) begin
                rsp_status = hpt_pkg::ST_INVALID;
              end else if (rd_data.tag != hpt_pkg::TAG_VALID || rd_data.pos < cur_pos) begin
                mem_we    = 1'b1;
                mem_wdata = '{tag: hpt_pkg::TAG_VALID, pos: cur_pos};
              end
            end
            hpt_pkg::KIND_UNSET: begin
              mem_we    = 1'b1;
              mem_wdata = '{tag: hpt_pkg::TAG_EMPTY, pos: '0};
            end
            hpt_pkg::KIND_RESET: begin
              mem_we = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = hpt_pkg::BK_IDLE;
      end
    endcase

    // Take the next queued operation as soon as the previous one is finished.
    if (dispatch) begin
      state_next = hpt_pkg::BK_IDLE;
      if (!q_empty) begin
        q_pop         = 1'b1;
        cur_kind_next = q_item.kind;
        cur_pos_next  = q_item.pos;
        if (q_item.kind == hpt_pkg::KIND_CLEAR) begin
          sweep_resp_next = 1'b1;
          state_next      = hpt_pkg::BK_SWEEP;
        end else if (IS_POW2) begin
          idx_next   = q_item.hash[IDX_W-1:0];
          state_next = hpt_pkg::BK_READ;
        end else begin
          prod_t      = PROD_W'(q_item.hash) * PROD_W'(RECIP);
          quo_t       = prod_t >> Q_SHIFT;
          mod_q_next  = quo_t[hpt_pkg::HASH_W-1:0];
          mod_sh_next = q_item.hash;
          state_next  = hpt_pkg::BK_MOD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == hpt_pkg::BK_READ) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_data.status         <= rsp_status;
      rsp_data.found_position <= rsp_found;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> (!rsp_valid || rsp.ready))
    else $error("result register overwritten before transfer");
  a_pop_state: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == hpt_pkg::BK_IDLE || state == hpt_pkg::BK_EXEC ||
               state == hpt_pkg::BK_CLR_DONE))
    else $error("operation taken while engine busy");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == hpt_pkg::BK_READ) |-> (idx <= LAST_ADDR))
    else $error("table index beyond depth");
`endif

endmodule

// File: rtl/hashed_position_table_core.sv
// Top level of the hashed position table: front end, queue and table engine.
// Path: a request is registered in the front end and queued; the engine then takes it
// through its read and execute states into the result register, with a modulo
// state first for a depth that is not a power of two (reciprocal index remainder).
// The engine takes a new operation only once the previous one has finished its
// memory read and read-modify-write; a clear first sweeps every entry.
// Reset: a sweep tags every entry search-required; no request is taken until it ends.
module hashed_position_table_core #(
  parameter int          TABLE_DEPTH    = 4096,
  parameter logic [31:0] POSITION_LIMIT = 32'hFFFF_FFFF
) (
  input  logic     clk,
  input  logic     rst,
  hpt_chan_if.sink req,
  hpt_chan_if.source rsp
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  logic             init_busy;
  hpt_pkg::q_item_t push_item;
  hpt_pkg::q_item_t pop_item;

  hpt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .hold   (init_busy),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (push_item)
  );

  hpt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  hpt_back #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .POSITION_LIMIT (POSITION_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .rsp       (rsp)
  );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for hashed_position_table_core with a shadow table predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hpt_pkg::*;

  localparam int          DEPTH     = 4096;
  localparam logic [31:0] LIMIT     = 32'hFFFF_FFFF;
  localparam int          HOT_SLOTS = 16;
  localparam int          RAND_OPS  = 1725;
  localparam int          SETTLE    = 20;

  // Kind codes that the block must treat as no-ops.
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam logic [255:0] KEY_ZERO = '0;
  localparam logic [255:0] KEY_ONES = '1;
  // Lands on the same slot as the all-ones key.
  localparam logic [255:0] KEY_ALIAS = 256'h0FF8;

  typedef struct {
    req_t op;
    bit   typed;
    rsp_t want;
  } step_row_t;

  logic clk;
  logic rst;

  hpt_chan_if #(.data_t(req_t)) req_if ();
  hpt_chan_if #(.data_t(rsp_t)) rsp_if ();

  hashed_position_table_core #(
    .TABLE_DEPTH(DEPTH),
    .POSITION_LIMIT(LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  tag_t        slot_tag [DEPTH];
  logic [31:0] slot_pos [DEPTH];
  rsp_t        due_results [$];
  step_row_t   plan [$];
  int          hot_slots [HOT_SLOTS];
  int          errors = 0;
  int          checked = 0;
  int          kind_count [8];
  bit          calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #10ms;
    $display("hashed_position_table_core test failed");
    $finish;
  end

  function automatic int slot_of(req_t op);
    logic [255:0] key;
    logic [31:0]  sum;
    key = {op.key_w3, op.key_w2, op.key_w1, op.key_w0};
    sum = '0;
    for (int i = 0; i < 8; i++) sum += key[32*i +: 32];
    return int'(sum % DEPTH);
  endfunction

  // Shadow of the entry store: applies one operation and returns its result.
  function automatic rsp_t shadow_apply(req_t op);
    rsp_t r;
    int   s;
    s = slot_of(op);
    r.status = ST_OK;
    r.found_position = '0;
    case (op.kind)
      KIND_GET: begin
        if (slot_tag[s] == TAG_SEARCH) r.status = ST_SEARCH;
        else if (slot_tag[s] != TAG_VALID) r.status = ST_NOENT;
        else r.found_position = slot_pos[s];
      end
      KIND_SET: begin
        if (op.new_position >= LIMIT) begin
          r.status = ST_INVALID;
        end else if (slot_tag[s] != TAG_VALID || slot_pos[s] < op.new_position) begin
          slot_tag[s] = TAG_VALID;
          slot_pos[s] = op.new_position;
        end
      end
      KIND_UNSET: begin
        slot_tag[s] = TAG_EMPTY;
        slot_pos[s] = '0;
      end
      KIND_RESET: begin
        slot_tag[s] = TAG_SEARCH;
        slot_pos[s] = '0;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) begin
          slot_tag[i] = TAG_SEARCH;
          slot_pos[i] = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random key whose word sum falls on the given slot.
  function automatic logic [255:0] key_at(int s);
    logic [255:0] key;
    logic [31:0]  sum;
    sum = '0;
    for (int i = 1; i < 8; i++) begin
      key[32*i +: 32] = $urandom();
      sum += key[32*i +: 32];
    end
    key[31:0] = 32'(s) - sum + 32'(DEPTH) * $urandom();
    return key;
  endfunction

  function automatic logic [31:0] pick_position();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LIMIT;
      2: return LIMIT - 1;
      3: return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  task automatic refresh_hot_slots();
    for (int i = 0; i < HOT_SLOTS; i++) begin
      case ($urandom_range(0, 7))
        0: hot_slots[i] = 0;
        1: hot_slots[i] = DEPTH - 1;
        default: hot_slots[i] = $urandom_range(0, DEPTH - 1);
      endcase
    end
  endtask

  task automatic add_row(input logic [2:0] kind, input logic [255:0] key,
                         input logic [31:0] pos, input bit typed,
                         input status_t st, input logic [31:0] found);
    step_row_t row;
    row.op.kind = kind;
    {row.op.key_w3, row.op.key_w2, row.op.key_w1, row.op.key_w0} = key;
    row.op.new_position = pos;
    row.typed = typed;
    row.want.status = st;
    row.want.found_position = found;
    plan.push_back(row);
  endtask

  // Valid stays high across back-to-back transfers; it only drops for a gap.
  task automatic send_op(input req_t op, input bit typed, input rsp_t want);
    int   gap;
    rsp_t predicted;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= op;
    do @(posedge clk); while (!req_if.ready);
    predicted = shadow_apply(op);
    due_results.push_back(typed ? want : predicted);
    kind_count[op.kind]++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  initial begin : result_side
    int   stall;
    rsp_t want;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      checked++;
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d found_position %0h",
               rsp_if.data.status, rsp_if.data.found_position);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (rsp_if.data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.data.status);
          errors++;
        end
        if (rsp_if.data.found_position !== want.found_position) begin
          $error("found_position: expected %0h, actual %0h",
                 want.found_position, rsp_if.data.found_position);
          errors++;
        end
      end
    end
  end

  initial begin : request_side
    req_t      op;
    rsp_t      none;
    logic [2:0] kind;
    int        pick;
    int        s;

    req_if.valid <= 1'b0;
    req_if.data <= '0;
    none = '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_tag[i] = TAG_SEARCH;
      slot_pos[i] = '0;
    end
    foreach (kind_count[i]) kind_count[i] = 0;

    add_row(KIND_GET, KEY_ZERO, '0, 1, ST_SEARCH, '0);
    add_row(KIND_SET, KEY_ZERO, LIMIT, 1, ST_INVALID, '0);
    add_row(KIND_SET, KEY_ZERO, '0, 1, ST_OK, '0);
    add_row(KIND_GET, KEY_ZERO, '1, 1, ST_OK, '0);
    add_row(KIND_SET, KEY_ONES, LIMIT - 1, 1, ST_OK, '0);
    add_row(KIND_SET, KEY_ONES, 32'd5, 1, ST_OK, '0);
    add_row(KIND_GET, KEY_ALIAS, '0, 1, ST_OK, LIMIT - 1);
    add_row(KIND_UNSET, KEY_ZERO, '1, 1, ST_OK, '0);
    add_row(KIND_GET, KEY_ZERO, '0, 1, ST_NOENT, '0);
    add_row(KIND_SET, KEY_ZERO, 32'h8000_0000, 1, ST_OK, '0);
    add_row(KIND_SET, KEY_ZERO, 32'h8000_0001, 1, ST_OK, '0);
    add_row(KIND_GET, KEY_ZERO, '0, 1, ST_OK, 32'h8000_0001);
    add_row(KIND_RESET, KEY_ZERO, '1, 1, ST_OK, '0);
    add_row(KIND_GET, KEY_ZERO, '0, 1, ST_SEARCH, '0);
    add_row(KIND_UNSET, KEY_ONES, '0, 1, ST_OK, '0);
    add_row(KIND_GET, KEY_ONES, '0, 1, ST_NOENT, '0);
    add_row(KIND_SET, KEY_ONES, '0, 1, ST_OK, '0);
    add_row(KIND_SPARE_LO, KEY_ZERO, '1, 1, ST_OK, '0);
    add_row(KIND_SPARE_MID, KEY_ONES, 32'd1, 1, ST_OK, '0);
    add_row(KIND_SPARE_HI, KEY_ONES, '1, 1, ST_OK, '0);
    add_row(KIND_GET, KEY_ONES, '0, 1, ST_OK, '0);
    add_row(KIND_SET, key_at(17), $urandom(), 0, ST_OK, '0);
    add_row(KIND_CLEAR, KEY_ONES, 32'h1234, 1, ST_OK, '0);
    add_row(KIND_GET, KEY_ONES, '0, 1, ST_SEARCH, '0);
    add_row(KIND_GET, key_at(17), '0, 0, ST_OK, '0);

    do @(posedge clk); while (rst);

    foreach (plan[i]) send_op(plan[i].op, plan[i].typed, plan[i].want);

    refresh_hot_slots();
    for (int n = 0; n < RAND_OPS; n++) begin
      // Every fifth stretch runs with no gaps on either side.
      calm = ((n / 150) % 5) == 4;
      pick = $urandom_range(0, 99);
      if (pick < 1) kind = KIND_CLEAR;
      else if (pick < 4) kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      else if (pick < 42) kind = KIND_GET;
      else if (pick < 74) kind = KIND_SET;
      else if (pick < 87) kind = KIND_UNSET;
      else kind = KIND_RESET;
      s = ($urandom_range(0, 4) == 0) ? $urandom_range(0, DEPTH - 1)
                                      : hot_slots[$urandom_range(0, HOT_SLOTS - 1)];
      op.kind = kind;
      {op.key_w3, op.key_w2, op.key_w1, op.key_w0} = key_at(s);
      op.new_position = pick_position();
      send_op(op, 1'b0, none);
      if (kind == KIND_CLEAR) refresh_hot_slots();
      if (n == RAND_OPS / 3) drain();
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d gets, %0d sets, %0d unsets, %0d resets, %0d clears, %0d no-op kinds.",
             kind_count[KIND_GET], kind_count[KIND_SET], kind_count[KIND_UNSET],
             kind_count[KIND_RESET], kind_count[KIND_CLEAR],
             kind_count[KIND_SPARE_LO] + kind_count[KIND_SPARE_MID]
             + kind_count[KIND_SPARE_HI]);
    $display("Compared %0d results against the shadow table, %0d mismatches.",
             checked, errors);
    if (errors == 0) begin
      $display("hashed_position_table_core test passed");
    end else begin
      $display("hashed_position_table_core test failed");
    end
    $finish;
  end

endmodule
